>>> hw/rtl/fbb_pkg.sv
// Shared types and fixed constants of the figure bounding box unit.
// Used by fbb_sqrt, fbb_div, figure_bounding_box_unit and tb_top; depends on nothing.
package fbb_pkg;

    // Figure type codes carried on the func field. Codes 6 and 7 are unused.
    typedef enum logic [2:0] {
        FN_SEGMENT  = 3'd0,
        FN_TRIANGLE = 3'd1,
        FN_QUAD     = 3'd2,
        FN_RECT     = 3'd3,
        FN_SQUARE   = 3'd4,
        FN_CIRCLE   = 3'd5
    } t_func;

    // The base vector is normalized so that its larger component lies in [2^30, 2^31).
    localparam int UNIT_W      = 31;
    localparam int UNIT_SHIFT  = 30;

    // Square root of the squared length of the normalized vector.
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STAGES = ROOT_W;

    // Unit vector component: (n * 2^30 + root / 2) / root, quotient at most 2^30.
    localparam int NUM_W       = 62;
    localparam int DEN_W       = 32;
    localparam int QUO_W       = 31;
    localparam int DIV_STAGES  = QUO_W;

endpackage

>>> hw/rtl/fbb_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on fbb_pkg for the radicand and root widths.
module fbb_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [fbb_pkg::RAD_W-1:0]    i_rad,
    output logic                         o_vld,
    output logic [fbb_pkg::ROOT_W-1:0]   o_root
);
    import fbb_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int T_W   = REM_W + 2;

    logic                r_vld  [0:SQRT_STAGES-1];
    logic [REM_W-1:0]    r_rem  [0:SQRT_STAGES-1];
    logic [ROOT_W-1:0]   r_root [0:SQRT_STAGES-1];
    logic [RAD_W-1:0]    r_rad  [0:SQRT_STAGES-1];

    logic                n_vld  [0:SQRT_STAGES-1];
    logic [REM_W-1:0]    n_rem  [0:SQRT_STAGES-1];
    logic [ROOT_W-1:0]   n_root [0:SQRT_STAGES-1];
    logic [RAD_W-1:0]    n_rad  [0:SQRT_STAGES-1];

    // Each stage brings down the next pair of radicand bits and tries one root bit.
    always_comb begin
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        logic              p_vld;
        logic [T_W-1:0]    t;
        logic [T_W-1:0]    trial;
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                p_vld  = i_vld;
                p_rem  = '0;
                p_root = '0;
                p_rad  = i_rad;
            end else begin
                p_vld  = r_vld[k-1];
                p_rem  = r_rem[k-1];
                p_root = r_root[k-1];
                p_rad  = r_rad[k-1];
            end
            t     = {p_rem, p_rad[2*(SQRT_STAGES-1-k) +: 2]};
            trial = T_W'({p_root, 2'b01});
            if (t >= trial) begin
                n_rem[k]  = REM_W'(t - trial);
                n_root[k] = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = t[REM_W-1:0];
                n_root[k] = {p_root[ROOT_W-2:0], 1'b0};
            end
            n_vld[k] = p_vld;
            n_rad[k] = p_rad;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_rad[k]  <= n_rad[k];
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_root[SQRT_STAGES-1];

endmodule

>>> hw/rtl/fbb_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fbb_pkg; the quotient must fit in QUO_W bits.
module fbb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [fbb_pkg::NUM_W-1:0]   i_num,
    input  logic [fbb_pkg::DEN_W-1:0]   i_den,
    output logic                        o_vld,
    output logic [fbb_pkg::QUO_W-1:0]   o_quo
);
    import fbb_pkg::*;

    logic               r_vld [0:DIV_STAGES-1];
    logic [DEN_W-1:0]   r_rem [0:DIV_STAGES-1];
    logic [QUO_W-1:0]   r_quo [0:DIV_STAGES-1];
    logic [NUM_W-1:0]   r_num [0:DIV_STAGES-1];
    logic [DEN_W-1:0]   r_den [0:DIV_STAGES-1];

    logic               n_vld [0:DIV_STAGES-1];
    logic [DEN_W-1:0]   n_rem [0:DIV_STAGES-1];
    logic [QUO_W-1:0]   n_quo [0:DIV_STAGES-1];
    logic [NUM_W-1:0]   n_num [0:DIV_STAGES-1];
    logic [DEN_W-1:0]   n_den [0:DIV_STAGES-1];

    // Each stage shifts in one dividend bit and subtracts the divisor when it fits.
    always_comb begin
        logic             p_vld;
        logic [DEN_W-1:0] p_rem;
        logic [QUO_W-1:0] p_quo;
        logic [NUM_W-1:0] p_num;
        logic [DEN_W-1:0] p_den;
        logic [DEN_W:0]   t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                p_vld = i_vld;
                p_rem = DEN_W'(i_num[NUM_W-1:QUO_W]);
                p_quo = '0;
                p_num = i_num;
                p_den = i_den;
            end else begin
                p_vld = r_vld[k-1];
                p_rem = r_rem[k-1];
                p_quo = r_quo[k-1];
                p_num = r_num[k-1];
                p_den = r_den[k-1];
            end
            t = {p_rem, p_num[QUO_W-1-k]};
            if (t >= {1'b0, p_den}) begin
                n_rem[k] = DEN_W'(t - {1'b0, p_den});
                n_quo[k] = {p_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DEN_W-1:0];
                n_quo[k] = {p_quo[QUO_W-2:0], 1'b0};
            end
            n_vld[k] = p_vld;
            n_num[k] = p_num;
            n_den[k] = p_den;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_rem[k] <= n_rem[k];
            r_quo[k] <= n_quo[k];
            r_num[k] <= n_num[k];
            r_den[k] <= n_den[k];
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

>>> hw/rtl/figure_bounding_box_unit.sv
// Figure bounding box unit: top level, a fully pipelined datapath.
// Depends on fbb_pkg, fbb_sqrt and fbb_div.
//
// Usage:
//   A figure request is taken at a rising edge where start is high and busy is
//   low. busy is always low, so a new request can be issued in every cycle.
//   Each request gives exactly one result, shown on the o_ ports for one cycle
//   with o_valid high. Results leave in request order. The receiver cannot
//   stall the block and needs none. Throughput is one figure per cycle; the
//   result path runs through the 32-stage square root and the 31-stage
//   dividers that form the unit vector of a rectangle base, which every
//   figure passes through so that order is kept.
//   Rectangles get C and D from A, B and the side length; squares get B and D
//   from the diagonal A to C. All outputs saturate to the coordinate range.
//   Synchronous reset clears every valid bit; nothing is in flight afterwards
//   and no result appears until a new request enters.
module figure_bounding_box_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_func,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_px_d,
    input  logic signed [COORD_WIDTH-1:0] i_py_d,
    input  logic signed [COORD_WIDTH-1:0] i_extent,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_box_x,
    output logic signed [COORD_WIDTH-1:0] o_box_y,
    output logic signed [COORD_WIDTH-1:0] o_box_w,
    output logic signed [COORD_WIDTH-1:0] o_box_h,
    output logic signed [COORD_WIDTH-1:0] o_corner1_x,
    output logic signed [COORD_WIDTH-1:0] o_corner1_y,
    output logic signed [COORD_WIDTH-1:0] o_corner2_x,
    output logic signed [COORD_WIDTH-1:0] o_corner2_y
);
    import fbb_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int MW   = W + 1;
    localparam int SH_W = $clog2(MW + 1);
    localparam int PW   = W + UNIT_W;

    // Alignment of each register set with the request delay line.
    localparam int IX_SQ    = 4 + SQRT_STAGES;
    localparam int IX_DIV   = IX_SQ + 1 + DIV_STAGES;
    localparam int IX_MUL   = IX_DIV + 1;
    localparam int IX_RND   = IX_MUL + 1;
    localparam int DEPTH    = IX_RND + 1;
    localparam int NX_DEPTH = IX_SQ - 1;
    localparam int LAT      = IX_RND + 4;

    // Coordinate slots of a request.
    localparam int NPT   = 9;
    localparam int P_AX  = 0;
    localparam int P_AY  = 1;
    localparam int P_BX  = 2;
    localparam int P_BY  = 3;
    localparam int P_CX  = 4;
    localparam int P_CY  = 5;
    localparam int P_DX  = 6;
    localparam int P_DY  = 7;
    localparam int P_EXT = 8;

    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};
    localparam logic [PW:0]         RND_HALF = (PW+1)'(1) << (UNIT_SHIFT - 1);

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+1:0] v);
        logic signed [W+1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return $signed(c[W-1:0]);
    endfunction

    function automatic logic signed [W+1:0] f_ext(input logic signed [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    // ---------------------------------------------------------------------
    // Request delay line: figure type and coordinates travel with a valid bit.
    logic                r_vld [0:DEPTH-1];
    logic [2:0]          r_fn  [0:DEPTH-1];
    logic signed [W-1:0] r_fig [0:DEPTH-1][0:NPT-1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn[0]         <= i_func;
        r_fig[0][P_AX]  <= i_ax;
        r_fig[0][P_AY]  <= i_ay;
        r_fig[0][P_BX]  <= i_bx;
        r_fig[0][P_BY]  <= i_by;
        r_fig[0][P_CX]  <= i_cx;
        r_fig[0][P_CY]  <= i_cy;
        r_fig[0][P_DX]  <= i_px_d;
        r_fig[0][P_DY]  <= i_py_d;
        r_fig[0][P_EXT] <= i_extent;
        for (int k = 1; k < DEPTH; k++) begin
            r_fn[k]  <= r_fn[k-1];
            r_fig[k] <= r_fig[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // Base vector B - A and its component magnitudes.
    logic [MW-1:0] r_s2_mx;
    logic [MW-1:0] r_s2_my;

    always_ff @(posedge i_clk) begin
        logic signed [MW-1:0] d_x;
        logic signed [MW-1:0] d_y;
        d_x = MW'(r_fig[0][P_BX]) - MW'(r_fig[0][P_AX]);
        d_y = MW'(r_fig[0][P_BY]) - MW'(r_fig[0][P_AY]);
        r_s2_mx <= d_x[MW-1] ? MW'(-d_x) : MW'(d_x);
        r_s2_my <= d_y[MW-1] ? MW'(-d_y) : MW'(d_y);
    end

    // Normalize both magnitudes by one power of two; the result travels on
    // its own delay line up to the divider setup.
    logic [UNIT_W-1:0] r_nx [0:NX_DEPTH-1];
    logic [UNIT_W-1:0] r_ny [0:NX_DEPTH-1];
    logic [UNIT_W-1:0] n_nx;
    logic [UNIT_W-1:0] n_ny;

    always_comb begin
        logic [MW-1:0]   m;
        logic [SH_W-1:0] p;
        logic [SH_W-1:0] sh;
        m = (r_s2_mx > r_s2_my) ? r_s2_mx : r_s2_my;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (m[i]) begin
                p = SH_W'(i);
            end
        end
        sh   = p + SH_W'(1);
        n_nx = UNIT_W'({r_s2_mx, {UNIT_W{1'b0}}} >> sh);
        n_ny = UNIT_W'({r_s2_my, {UNIT_W{1'b0}}} >> sh);
    end

    always_ff @(posedge i_clk) begin
        r_nx[0] <= n_nx;
        r_ny[0] <= n_ny;
        for (int k = 1; k < NX_DEPTH; k++) begin
            r_nx[k] <= r_nx[k-1];
            r_ny[k] <= r_ny[k-1];
        end
    end

    // Squares, then the squared length.
    logic [2*UNIT_W-1:0] r_s4_sqx;
    logic [2*UNIT_W-1:0] r_s4_sqy;
    logic [2*UNIT_W:0]   r_s5_sum;

    always_ff @(posedge i_clk) begin
        r_s4_sqx <= r_nx[0] * r_nx[0];
        r_s4_sqy <= r_ny[0] * r_ny[0];
        r_s5_sum <= {1'b0, r_s4_sqx} + {1'b0, r_s4_sqy};
    end

    // Length of the normalized vector.
    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_sq_root;

    fbb_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[4]),
        .i_rad   (RAD_W'(r_s5_sum)),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root)
    );

    // Divider setup: component * 2^30 plus half the length, rounding to nearest.
    logic             r_dv_vld;
    logic [NUM_W-1:0] r_dv_numx;
    logic [NUM_W-1:0] r_dv_numy;
    logic [DEN_W-1:0] r_dv_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= 1'b0;
        end else begin
            r_dv_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_numx <= NUM_W'({r_nx[NX_DEPTH-1], {UNIT_SHIFT{1'b0}}})
                   + NUM_W'(w_sq_root[ROOT_W-1:1]);
        r_dv_numy <= NUM_W'({r_ny[NX_DEPTH-1], {UNIT_SHIFT{1'b0}}})
                   + NUM_W'(w_sq_root[ROOT_W-1:1]);
        r_dv_den  <= DEN_W'(w_sq_root);
    end

    // Unit vector components in Q1.30.
    logic             w_dvx_vld;
    logic             w_dvy_vld;
    logic [QUO_W-1:0] w_ux;
    logic [QUO_W-1:0] w_uy;

    fbb_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_dv_vld),
        .i_num   (r_dv_numx),
        .i_den   (r_dv_den),
        .o_vld   (w_dvx_vld),
        .o_quo   (w_ux)
    );

    fbb_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_dv_vld),
        .i_num   (r_dv_numy),
        .i_den   (r_dv_den),
        .o_vld   (w_dvy_vld),
        .o_quo   (w_uy)
    );

    // Scale the unit vector by the side length magnitude.
    logic [PW-1:0] r_mul_px;
    logic [PW-1:0] r_mul_py;

    always_ff @(posedge i_clk) begin
        logic signed [W-1:0] l;
        logic [W-1:0]        ml;
        l  = r_fig[IX_DIV][P_EXT];
        ml = l[W-1] ? W'(-l) : W'(l);
        r_mul_px <= ml * w_uy;
        r_mul_py <= ml * w_ux;
    end

    // Round to nearest and apply the rotation signs to get the offset t.
    logic signed [W:0] r_rnd_tx;
    logic signed [W:0] r_rnd_ty;

    always_ff @(posedge i_clk) begin
        logic [PW:0]  s_x;
        logic [PW:0]  s_y;
        logic [W-1:0] mx;
        logic [W-1:0] my;
        logic         l_neg;
        logic         neg_x;
        logic         pos_y;
        s_x   = {1'b0, r_mul_px} + RND_HALF;
        s_y   = {1'b0, r_mul_py} + RND_HALF;
        mx    = W'(s_x >> UNIT_SHIFT);
        my    = W'(s_y >> UNIT_SHIFT);
        l_neg = r_fig[IX_MUL][P_EXT][W-1];
        neg_x = (r_fig[IX_MUL][P_BY] < r_fig[IX_MUL][P_AY]) != l_neg;
        pos_y = (r_fig[IX_MUL][P_BX] < r_fig[IX_MUL][P_AX]) != l_neg;
        r_rnd_tx <= neg_x ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        r_rnd_ty <= pos_y ? $signed({1'b0, my}) : -$signed({1'b0, my});
    end

    // ---------------------------------------------------------------------
    // Point set of the figure, derived corners and circle box.
    logic                r_pt_vld;
    logic [2:0]          r_pt_fn;
    logic [2:0]          r_pt_n;
    logic signed [W-1:0] r_pt_x [0:3];
    logic signed [W-1:0] r_pt_y [0:3];
    logic signed [W-1:0] r_pt_c1x;
    logic signed [W-1:0] r_pt_c1y;
    logic signed [W-1:0] r_pt_c2x;
    logic signed [W-1:0] r_pt_c2y;
    logic signed [W-1:0] r_pt_cbx;
    logic signed [W-1:0] r_pt_cby;
    logic signed [W-1:0] r_pt_cbs;

    logic [2:0]          n_pt_n;
    logic signed [W-1:0] n_pt_x [0:3];
    logic signed [W-1:0] n_pt_y [0:3];
    logic signed [W-1:0] n_c1x;
    logic signed [W-1:0] n_c1y;
    logic signed [W-1:0] n_c2x;
    logic signed [W-1:0] n_c2y;

    always_comb begin
        logic signed [W+1:0] ax;
        logic signed [W+1:0] ay;
        logic signed [W+1:0] bx;
        logic signed [W+1:0] by;
        logic signed [W+1:0] cx;
        logic signed [W+1:0] cy;
        logic signed [W+1:0] tx;
        logic signed [W+1:0] ty;
        logic signed [W+1:0] s1x;
        logic signed [W+1:0] s1y;
        logic signed [W+1:0] s3x;
        logic signed [W+1:0] s3y;
        logic                rect_zero;
        logic                sq_zero;
        ax = f_ext(r_fig[IX_RND][P_AX]);
        ay = f_ext(r_fig[IX_RND][P_AY]);
        bx = f_ext(r_fig[IX_RND][P_BX]);
        by = f_ext(r_fig[IX_RND][P_BY]);
        cx = f_ext(r_fig[IX_RND][P_CX]);
        cy = f_ext(r_fig[IX_RND][P_CY]);
        tx = {r_rnd_tx[W], r_rnd_tx};
        ty = {r_rnd_ty[W], r_rnd_ty};
        s1x = (ax + cx + cy - ay) >>> 1;
        s1y = (ay + cy - cx + ax) >>> 1;
        s3x = (ax + cx - cy + ay) >>> 1;
        s3y = (ay + cy + cx - ax) >>> 1;
        rect_zero = (bx == ax) && (by == ay);
        sq_zero   = (cx == ax) && (cy == ay);

        n_pt_x[0] = r_fig[IX_RND][P_AX];
        n_pt_y[0] = r_fig[IX_RND][P_AY];
        n_pt_x[1] = r_fig[IX_RND][P_BX];
        n_pt_y[1] = r_fig[IX_RND][P_BY];
        n_pt_x[2] = r_fig[IX_RND][P_CX];
        n_pt_y[2] = r_fig[IX_RND][P_CY];
        n_pt_x[3] = r_fig[IX_RND][P_DX];
        n_pt_y[3] = r_fig[IX_RND][P_DY];
        n_c1x = '0;
        n_c1y = '0;
        n_c2x = '0;
        n_c2y = '0;
        n_pt_n = 3'd0;

        case (r_fn[IX_RND])
            FN_SEGMENT: begin
                n_pt_n = 3'd2;
            end
            FN_TRIANGLE: begin
                n_pt_n = 3'd3;
            end
            FN_QUAD: begin
                n_pt_n = 3'd4;
            end
            FN_RECT: begin
                n_pt_n = 3'd4;
                if (rect_zero) begin
                    n_pt_x[2] = r_fig[IX_RND][P_AX];
                    n_pt_y[2] = r_fig[IX_RND][P_AY];
                    n_pt_x[3] = r_fig[IX_RND][P_AX];
                    n_pt_y[3] = r_fig[IX_RND][P_AY];
                end else begin
                    n_pt_x[2] = f_sat(bx + tx);
                    n_pt_y[2] = f_sat(by + ty);
                    n_pt_x[3] = f_sat(ax + tx);
                    n_pt_y[3] = f_sat(ay + ty);
                end
                n_c1x = n_pt_x[2];
                n_c1y = n_pt_y[2];
                n_c2x = n_pt_x[3];
                n_c2y = n_pt_y[3];
            end
            FN_SQUARE: begin
                n_pt_n = 3'd4;
                if (sq_zero) begin
                    n_pt_x[1] = r_fig[IX_RND][P_AX];
                    n_pt_y[1] = r_fig[IX_RND][P_AY];
                    n_pt_x[3] = r_fig[IX_RND][P_AX];
                    n_pt_y[3] = r_fig[IX_RND][P_AY];
                end else begin
                    n_pt_x[1] = f_sat(s1x);
                    n_pt_y[1] = f_sat(s1y);
                    n_pt_x[3] = f_sat(s3x);
                    n_pt_y[3] = f_sat(s3y);
                end
                n_c1x = n_pt_x[1];
                n_c1y = n_pt_y[1];
                n_c2x = n_pt_x[3];
                n_c2y = n_pt_y[3];
            end
            default: begin
                n_pt_n = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_vld <= 1'b0;
        end else begin
            r_pt_vld <= r_vld[IX_RND];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [W+1:0] ax;
        logic signed [W+1:0] ay;
        logic signed [W+1:0] ex;
        ax = f_ext(r_fig[IX_RND][P_AX]);
        ay = f_ext(r_fig[IX_RND][P_AY]);
        ex = f_ext(r_fig[IX_RND][P_EXT]);
        r_pt_fn  <= r_fn[IX_RND];
        r_pt_n   <= n_pt_n;
        r_pt_x   <= n_pt_x;
        r_pt_y   <= n_pt_y;
        r_pt_c1x <= n_c1x;
        r_pt_c1y <= n_c1y;
        r_pt_c2x <= n_c2x;
        r_pt_c2y <= n_c2y;
        r_pt_cbx <= f_sat(ax - ex);
        r_pt_cby <= f_sat(ay - ex);
        r_pt_cbs <= f_sat(ex + ex);
    end

    // ---------------------------------------------------------------------
    // Minimum and maximum over the points that the figure uses.
    logic                r_mm_vld;
    logic [2:0]          r_mm_fn;
    logic signed [W-1:0] r_mm_lx;
    logic signed [W-1:0] r_mm_hx;
    logic signed [W-1:0] r_mm_ly;
    logic signed [W-1:0] r_mm_hy;
    logic signed [W-1:0] r_mm_c1x;
    logic signed [W-1:0] r_mm_c1y;
    logic signed [W-1:0] r_mm_c2x;
    logic signed [W-1:0] r_mm_c2y;
    logic signed [W-1:0] r_mm_cbx;
    logic signed [W-1:0] r_mm_cby;
    logic signed [W-1:0] r_mm_cbs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_vld <= 1'b0;
        end else begin
            r_mm_vld <= r_pt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [W-1:0] lx;
        logic signed [W-1:0] hx;
        logic signed [W-1:0] ly;
        logic signed [W-1:0] hy;
        lx = r_pt_x[0];
        hx = r_pt_x[0];
        ly = r_pt_y[0];
        hy = r_pt_y[0];
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < r_pt_n) begin
                if (r_pt_x[i] < lx) lx = r_pt_x[i];
                if (r_pt_x[i] > hx) hx = r_pt_x[i];
                if (r_pt_y[i] < ly) ly = r_pt_y[i];
                if (r_pt_y[i] > hy) hy = r_pt_y[i];
            end
        end
        r_mm_fn  <= r_pt_fn;
        r_mm_lx  <= lx;
        r_mm_hx  <= hx;
        r_mm_ly  <= ly;
        r_mm_hy  <= hy;
        r_mm_c1x <= r_pt_c1x;
        r_mm_c1y <= r_pt_c1y;
        r_mm_c2x <= r_pt_c2x;
        r_mm_c2y <= r_pt_c2y;
        r_mm_cbx <= r_pt_cbx;
        r_mm_cby <= r_pt_cby;
        r_mm_cbs <= r_pt_cbs;
    end

    // ---------------------------------------------------------------------
    // Result register: box size and selection by figure type.
    logic                r_out_vld;
    logic signed [W-1:0] r_out_bx;
    logic signed [W-1:0] r_out_by;
    logic signed [W-1:0] r_out_bw;
    logic signed [W-1:0] r_out_bh;
    logic signed [W-1:0] r_out_c1x;
    logic signed [W-1:0] r_out_c1y;
    logic signed [W-1:0] r_out_c2x;
    logic signed [W-1:0] r_out_c2y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_mm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_mm_fn)
            FN_SEGMENT, FN_TRIANGLE, FN_QUAD, FN_RECT, FN_SQUARE: begin
                r_out_bx  <= r_mm_lx;
                r_out_by  <= r_mm_ly;
                r_out_bw  <= f_sat(f_ext(r_mm_hx) - f_ext(r_mm_lx));
                r_out_bh  <= f_sat(f_ext(r_mm_hy) - f_ext(r_mm_ly));
                r_out_c1x <= r_mm_c1x;
                r_out_c1y <= r_mm_c1y;
                r_out_c2x <= r_mm_c2x;
                r_out_c2y <= r_mm_c2y;
            end
            FN_CIRCLE: begin
                r_out_bx  <= r_mm_cbx;
                r_out_by  <= r_mm_cby;
                r_out_bw  <= r_mm_cbs;
                r_out_bh  <= r_mm_cbs;
                r_out_c1x <= '0;
                r_out_c1y <= '0;
                r_out_c2x <= '0;
                r_out_c2y <= '0;
            end
            default: begin
                r_out_bx  <= '0;
                r_out_by  <= '0;
                r_out_bw  <= '0;
                r_out_bh  <= '0;
                r_out_c1x <= '0;
                r_out_c1y <= '0;
                r_out_c2x <= '0;
                r_out_c2y <= '0;
            end
        endcase
    end

    assign o_valid     = r_out_vld;
    assign o_box_x     = r_out_bx;
    assign o_box_y     = r_out_by;
    assign o_box_w     = r_out_bw;
    assign o_box_h     = r_out_bh;
    assign o_corner1_x = r_out_c1x;
    assign o_corner1_y = r_out_c1y;
    assign o_corner2_x = r_out_c2x;
    assign o_corner2_y = r_out_c2y;

    // ---------------------------------------------------------------------
    // The root unit stays in step with the request delay line.
    a_sqrt_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_vld == r_vld[IX_SQ])
        else $error("square root valid out of step with request line");

    // Both dividers stay in step with the request delay line.
    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dvx_vld == r_vld[IX_DIV]) && (w_dvy_vld == w_dvx_vld))
        else $error("divider valid out of step with request line");

    // Every accepted request yields its result after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after an accepted request");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the figure bounding box unit: a queued driver, a
// strobe monitor and a bit-exact predictor of the box and derived corners.
// Depends on fbb_pkg and figure_bounding_box_unit.
`timescale 1ns / 1ps

module tb_top;
    import fbb_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = 74;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic signed [63:0] S_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy, ext;
    } t_figure;

    typedef struct packed {
        logic signed [W-1:0] bx, by, bw, bh, c1x, c1y, c2x, c2y;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, o_valid;
    logic [2:0] i_func = '0;
    logic signed [W-1:0] i_ax = '0, i_ay = '0, i_bx = '0, i_by = '0, i_cx = '0, i_cy = '0;
    logic signed [W-1:0] i_px_d = '0, i_py_d = '0, i_extent = '0;
    logic signed [W-1:0] o_box_x, o_box_y, o_box_w, o_box_h;
    logic signed [W-1:0] o_corner1_x, o_corner1_y, o_corner2_x, o_corner2_y;

    t_figure pending_figs[$];
    t_box    expected_boxes[$];
    int      pause_mark[$];
    int      mismatches = 0;
    int      sent = 0;
    int      gap = 0;
    int      idle_cycles = 0;
    bit      stim_done = 0;

    figure_bounding_box_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by(i_by),
        .i_cx(i_cx), .i_cy(i_cy), .i_px_d(i_px_d), .i_py_d(i_py_d),
        .i_extent(i_extent), .o_valid(o_valid), .o_box_x(o_box_x),
        .o_box_y(o_box_y), .o_box_w(o_box_w), .o_box_h(o_box_h),
        .o_corner1_x(o_corner1_x), .o_corner1_y(o_corner1_y),
        .o_corner2_x(o_corner2_x), .o_corner2_y(o_corner2_y)
    );

    // Clock generation.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
        if (v > S_MAX) return S_MAX;
        if (v < S_MIN) return S_MIN;
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Scale a Q1.30 unit component by the side length, rounding ties up.
    function automatic logic [63:0] scale_q30(input logic [63:0] l, input logic [63:0] u);
        logic [63:0] hi, lo, rest;
        hi = (l >> 24) * u;
        lo = (l & 64'hFFFFFF) * u;
        rest = ((hi & 64'd63) << 24) + lo + (64'd1 << 29);
        return (hi >> 6) + (rest >> 30);
    endfunction

    function automatic logic [63:0] absval(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] half_floor(input logic signed [63:0] v);
        return v >>> 1;
    endfunction

    // Offset from the base to the far side of a rectangle.
    function automatic void side_offset(input logic signed [63:0] ddx, ddy, len,
                                        output logic signed [63:0] tx, ty);
        logic [63:0] mx, my, m, nm, ux, uy, ml, px, py;
        mx = absval(ddx);
        my = absval(ddy);
        m = mx > my ? mx : my;
        while (m >= (64'd1 << 31)) begin
            mx >>= 1; my >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            mx <<= 1; my <<= 1; m <<= 1;
        end
        nm = root64(mx * mx + my * my);
        ux = ((mx << 30) + nm / 2) / nm;
        uy = ((my << 30) + nm / 2) / nm;
        ml = absval(len);
        px = scale_q30(ml, uy);
        py = scale_q30(ml, ux);
        tx = ((ddy < 0) != (len < 0)) ? -$signed(px) : $signed(px);
        ty = ((ddx < 0) != (len < 0)) ? $signed(py) : -$signed(py);
    endfunction

    function automatic t_box bounding_box(input t_figure f);
        logic signed [63:0] px[4], py[4], rs[8], tx, ty, lx, hx, ly, hy;
        logic signed [63:0] ax, ay, bx, by, cx, cy;
        int n;
        t_box b;
        ax = f.ax; ay = f.ay; bx = f.bx; by = f.by; cx = f.cx; cy = f.cy;
        n = 0;
        for (int i = 0; i < 8; i++) rs[i] = 0;
        px[0] = ax; py[0] = ay;
        case (f.func)
            FN_SEGMENT, FN_TRIANGLE, FN_QUAD: begin
                px[1] = bx; py[1] = by; px[2] = cx; py[2] = cy;
                px[3] = f.dx; py[3] = f.dy;
                n = int'(f.func) + 2;
            end
            FN_RECT: begin
                px[1] = bx; py[1] = by;
                if (bx == ax && by == ay) begin
                    px[2] = ax; py[2] = ay; px[3] = ax; py[3] = ay;
                end else begin
                    side_offset(bx - ax, by - ay, f.ext, tx, ty);
                    px[2] = clamp(bx + tx); py[2] = clamp(by + ty);
                    px[3] = clamp(ax + tx); py[3] = clamp(ay + ty);
                end
                rs[4] = px[2]; rs[5] = py[2]; rs[6] = px[3]; rs[7] = py[3];
                n = 4;
            end
            FN_SQUARE: begin
                if (cx == ax && cy == ay) begin
                    px[1] = ax; py[1] = ay; px[3] = ax; py[3] = ay;
                end else begin
                    px[1] = clamp(half_floor(ax + cx + cy - ay));
                    py[1] = clamp(half_floor(ay + cy - cx + ax));
                    px[3] = clamp(half_floor(ax + cx - cy + ay));
                    py[3] = clamp(half_floor(ay + cy + cx - ax));
                end
                px[2] = cx; py[2] = cy;
                rs[4] = px[1]; rs[5] = py[1]; rs[6] = px[3]; rs[7] = py[3];
                n = 4;
            end
            FN_CIRCLE: begin
                rs[0] = clamp(ax - f.ext);
                rs[1] = clamp(ay - f.ext);
                rs[2] = clamp(2 * 64'(f.ext));
                rs[3] = rs[2];
            end
            default: ;
        endcase
        if (n > 0) begin
            lx = px[0]; hx = px[0]; ly = py[0]; hy = py[0];
            for (int i = 1; i < n; i++) begin
                if (px[i] < lx) lx = px[i];
                if (px[i] > hx) hx = px[i];
                if (py[i] < ly) ly = py[i];
                if (py[i] > hy) hy = py[i];
            end
            rs[0] = lx; rs[1] = ly; rs[2] = clamp(hx - lx); rs[3] = clamp(hy - ly);
        end
        b.bx = rs[0]; b.by = rs[1]; b.bw = rs[2]; b.bh = rs[3];
        b.c1x = rs[4]; b.c1y = rs[5]; b.c2x = rs[6]; b.c2y = rs[7];
        return b;
    endfunction

    // Coordinates: mostly small values, sometimes extremes or full range.
    function automatic logic signed [W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $signed($urandom_range(0, 64)) - 32;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic t_figure random_figure();
        t_figure f;
        f.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
        f.ax = pick_coord(); f.ay = pick_coord(); f.bx = pick_coord();
        f.by = pick_coord(); f.cx = pick_coord(); f.cy = pick_coord();
        f.dx = pick_coord(); f.dy = pick_coord(); f.ext = pick_coord();
        // Degenerate bases now and then.
        if ($urandom_range(0, 15) == 0) begin
            f.bx = f.ax; f.by = f.ay; f.cx = f.ax; f.cy = f.ay;
        end
        return f;
    endfunction

    function automatic t_figure make_fig(input logic [2:0] fn, input logic signed [W-1:0] a,
                                         input logic signed [W-1:0] b, input logic signed [W-1:0] e);
        t_figure f;
        f.func = fn;
        f.ax = a; f.ay = -a; f.bx = b; f.by = b; f.cx = -b; f.cy = a;
        f.dx = e; f.dy = -e; f.ext = e;
        return f;
    endfunction

    // Stimulus: directed figures, then random ones with one drain pause.
    initial begin
        logic signed [W-1:0] mx, mn;
        t_figure f;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        for (int fn = 0; fn < 8; fn++) begin
            pending_figs.push_back(make_fig(3'(fn), 32'sh0001_0000, 32'sh0005_0000, 32'sh0002_0000));
        end
        pending_figs.push_back(make_fig(FN_RECT, mx, mn, mx));
        pending_figs.push_back(make_fig(FN_RECT, mn, mx, mn));
        pending_figs.push_back(make_fig(FN_SQUARE, mx, mn, 0));
        pending_figs.push_back(make_fig(FN_SQUARE, mn, mx, 0));
        pending_figs.push_back(make_fig(FN_CIRCLE, mn, 0, mx));
        pending_figs.push_back(make_fig(FN_CIRCLE, mx, 0, mn));
        pending_figs.push_back(make_fig(FN_SEGMENT, mx, mn, 0));
        pending_figs.push_back(make_fig(FN_QUAD, mn, mx, -1));
        // Zero-length bases of a rectangle and a square.
        f = make_fig(FN_RECT, 32'sh0003_0000, 0, 32'sh0001_0000);
        f.bx = f.ax; f.by = f.ay;
        pending_figs.push_back(f);
        f.func = FN_SQUARE; f.cx = f.ax; f.cy = f.ay;
        pending_figs.push_back(f);
        // Negative radius and negative side length.
        pending_figs.push_back(make_fig(FN_CIRCLE, 32'sh0001_0000, 0, -32'sh0003_0000));
        pending_figs.push_back(make_fig(FN_RECT, 32'sh0001_0000, 32'sh0004_0000, -32'sh0003_0000));
        for (int i = 0; i < 1150; i++) begin
            if (i == 500) pause_mark.push_back(pending_figs.size());
            pending_figs.push_back(random_figure());
        end
        stim_done = 1;
    end

    // Driver: presents one request per accepting edge, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // Request not yet taken; hold it.
        end else if (pause_mark.size() > 0 && sent == pause_mark[0]) begin
            start <= 1'b0;
            if (!start && expected_boxes.size() == 0) void'(pause_mark.pop_front());
        end else if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
        end else if (pending_figs.size() > 0) begin
            t_figure f;
            f = pending_figs.pop_front();
            start <= 1'b1;
            i_func <= f.func; i_ax <= f.ax; i_ay <= f.ay; i_bx <= f.bx; i_by <= f.by;
            i_cx <= f.cx; i_cy <= f.cy; i_px_d <= f.dx; i_py_d <= f.dy; i_extent <= f.ext;
            sent <= sent + 1;
            case ($urandom_range(0, 19))
                0:       gap <= $urandom_range(20, 120);
                1, 2, 3: gap <= $urandom_range(1, 4);
                default: gap <= 0;
            endcase
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: records accepted requests and checks each strobed result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                t_figure f;
                f.func = i_func; f.ax = i_ax; f.ay = i_ay; f.bx = i_bx; f.by = i_by;
                f.cx = i_cx; f.cy = i_cy; f.dx = i_px_d; f.dy = i_py_d; f.ext = i_extent;
                expected_boxes.push_back(bounding_box(f));
            end
            if (o_valid) begin
                t_box got;
                got = '{o_box_x, o_box_y, o_box_w, o_box_h,
                        o_corner1_x, o_corner1_y, o_corner2_x, o_corner2_y};
                if (expected_boxes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %h", got);
                end else begin
                    t_box want;
                    want = expected_boxes.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no request or result moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset, then wait for the queue to drain before the final verdict.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (pending_figs.size() > 0 || start || expected_boxes.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_boxes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
